// ----- hdl/build_status_lamp_blinker_assert.svh -----
// assertion helpers for the lamp blinker, sampled on the block clock
`ifndef BUILD_STATUS_LAMP_BLINKER_ASSERT_SVH
`define BUILD_STATUS_LAMP_BLINKER_ASSERT_SVH

// plain property, held off while reset is high
`define BSLB_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// same-cycle implication, held off while reset is high
`define BSLB_ASSERT_IMPL(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

`endif

// ----- hdl/bslb_pkg.sv -----
`default_nettype none

package bslb_pkg;

   // fixed field and state widths
   localparam int TIME_W   = 12;
   localparam int MS_W     = 16;
   localparam int PERIOD_W = 12;
   localparam int LAMP_W   = 3;
   localparam int TIME_MAX = 4095;

   // two half periods make one blink
   localparam int BLINK_PHASES = 2;

   // reciprocal scaling for the elapsed-time divide
   localparam int RECIP_SHIFT = 28;
   localparam int RECIP_W     = RECIP_SHIFT + 1;

   // parameter defaults
   localparam int BLINK_PERIOD_MS_DEF = 500;
   localparam int BLINK_COUNT_DEF     = 3;

   // request kinds
   localparam logic REQ_SET  = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   // lamp bit positions
   localparam int LAMP_RED    = 0;
   localparam int LAMP_GREEN  = 1;
   localparam int LAMP_YELLOW = 2;

   typedef logic [LAMP_W-1:0] lamp_type;

   typedef enum logic [1:0] {
      BUILD_RUNNING      = 2'd0,
      BUILD_DISCONNECTED = 2'd1,
      BUILD_CORRECT      = 2'd2,
      BUILD_INCORRECT    = 2'd3
   } build_state_type;

   // request as registered at the input
   typedef struct packed {
      logic                 kind;
      build_state_type      state;
      logic [MS_W-1:0]      ms;
   } in_stage_type;

   // request with the estimated quotient of the elapsed time
   typedef struct packed {
      logic                 kind;
      build_state_type      state;
      logic [MS_W-1:0]      ms;
      logic [MS_W-1:0]      q_est;
   } est_stage_type;

   // request with elapsed time split into whole periods and remainder
   typedef struct packed {
      logic                 kind;
      build_state_type      state;
      logic [MS_W-1:0]      ms;
      logic [MS_W-1:0]      qm;
      logic [PERIOD_W-1:0]  rm;
   } div_stage_type;

   // lamp belonging to a build state
   function automatic lamp_type own_lamp(build_state_type st);
      lamp_type m;
      m = '0;
      case (st)
         BUILD_CORRECT:      m[LAMP_GREEN]  = 1'b1;
         BUILD_INCORRECT:    m[LAMP_RED]    = 1'b1;
         BUILD_RUNNING:      m[LAMP_YELLOW] = 1'b1;
         BUILD_DISCONNECTED: m[LAMP_YELLOW] = 1'b1;
         default:            m[LAMP_YELLOW] = 1'b1;
      endcase
      return m;
   endfunction

   // lamps left alone when entering a build state
   function automatic lamp_type keep_mask(build_state_type st);
      lamp_type m;
      m = '1;
      case (st)
         BUILD_RUNNING: begin
            m = '1;
         end
         BUILD_DISCONNECTED: begin
            m[LAMP_RED]   = 1'b0;
            m[LAMP_GREEN] = 1'b0;
         end
         BUILD_CORRECT: begin
            m[LAMP_RED]    = 1'b0;
            m[LAMP_YELLOW] = 1'b0;
         end
         BUILD_INCORRECT: begin
            m[LAMP_GREEN]  = 1'b0;
            m[LAMP_YELLOW] = 1'b0;
         end
         default: begin
            m = '1;
         end
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/bslb_if.sv -----
`default_nettype none

// request channel: set-state or tick
interface bslb_req_if;
   logic                        valid;
   logic                        ready;
   logic                        req_type;
   logic [1:0]                  new_state;
   logic [bslb_pkg::MS_W-1:0]   elapsed_ms;

   modport source (output valid, output req_type, output new_state, output elapsed_ms,
                   input ready);
   modport sink   (input valid, input req_type, input new_state, input elapsed_ms,
                   output ready);
endinterface

// response channel: lamp states after each request
interface bslb_rsp_if;
   logic valid;
   logic ready;
   logic red_lamp;
   logic green_lamp;
   logic yellow_lamp;
   logic animating;

   modport source (output valid, output red_lamp, output green_lamp, output yellow_lamp,
                   output animating, input ready);
   modport sink   (input valid, input red_lamp, input green_lamp, input yellow_lamp,
                   input animating, output ready);
endinterface

`default_nettype wire

// ----- hdl/build_status_lamp_blinker.sv -----
// Status lamp blinker: every request (set build state, or time tick) gives one
// response with the red, green and yellow lamps and the animation flag as they stand
// after it. A request is taken every clock cycle unless the response side holds off;
// each passes an input register, two stages that split the elapsed time into whole
// blink periods and a remainder (a reciprocal multiply, then a constant multiply with
// one correction), and the state register, which doubles as the response register.
// The combinational compare and subtract on the stored periods-and-remainder pair in
// the state stage sets the one-request-per-cycle rate. Reset leaves the block as a
// freshly attached controller: yellow lit, state disconnected, a full blink countdown
// running.
`default_nettype none

module build_status_lamp_blinker #(
   parameter int unsigned BLINK_PERIOD_MS = bslb_pkg::BLINK_PERIOD_MS_DEF,
   parameter int unsigned BLINK_COUNT     = bslb_pkg::BLINK_COUNT_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   bslb_req_if.sink         req,
   bslb_rsp_if.source       rsp
);

   localparam int TIME_W   = bslb_pkg::TIME_W;
   localparam int MS_W     = bslb_pkg::MS_W;
   localparam int PERIOD_W = bslb_pkg::PERIOD_W;
   localparam int RECIP_W  = bslb_pkg::RECIP_W;

   // countdown start, saturated to the time range, kept as periods plus remainder
   localparam int START_RAW = bslb_pkg::BLINK_PHASES * BLINK_PERIOD_MS * BLINK_COUNT;
   localparam int START     = (START_RAW > bslb_pkg::TIME_MAX) ? bslb_pkg::TIME_MAX
                                                                : START_RAW;
   localparam logic [TIME_W-1:0]   START_Q = TIME_W'(START / BLINK_PERIOD_MS);
   localparam logic [PERIOD_W-1:0] START_R = PERIOD_W'(START % BLINK_PERIOD_MS);
   localparam logic [PERIOD_W-1:0] PERIOD  = PERIOD_W'(BLINK_PERIOD_MS);
   localparam logic [RECIP_W-1:0]  RECIP   =
      RECIP_W'((64'd1 << bslb_pkg::RECIP_SHIFT) / BLINK_PERIOD_MS);

   // pipeline registers
   logic                          s0_valid_ff, s0_valid_in;
   logic                          s1_valid_ff, s1_valid_in;
   logic                          s2_valid_ff, s2_valid_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   bslb_pkg::in_stage_type        s0_ff, s0_in;
   bslb_pkg::est_stage_type       s1_ff, s1_in;
   bslb_pkg::div_stage_type       s2_ff, s2_in;

   // block state, shown directly on the response
   bslb_pkg::build_state_type     state_ff, state_in;
   logic [TIME_W-1:0]             q_ff, q_in;
   logic [PERIOD_W-1:0]           r_ff, r_in;
   logic                          active_ff, active_in;
   bslb_pkg::lamp_type            lamp_ff, lamp_in;

   // stage flow control
   logic ready0, ready1, ready2, out_load;

   // divide helpers
   logic [MS_W+RECIP_W-1:0]       prod_est;
   logic [MS_W+PERIOD_W-1:0]      prod_back;
   logic [MS_W-1:0]               r_est;

   // tick helpers
   logic [MS_W-1:0]               q_wide;
   logic                          tick_ends;
   logic                          borrow;
   logic [PERIOD_W:0]             r_sum;
   logic [TIME_W-1:0]             q_next;
   logic [PERIOD_W-1:0]           r_next;
   bslb_pkg::lamp_type            own;

   // elapsed split recombined for the divide check
   logic                          split_ok;

   // each stage takes a request when empty or when it hands its own on
   assign out_load = !rsp_valid_ff || rsp.ready;
   assign ready2   = !s2_valid_ff || out_load;
   assign ready1   = !s1_valid_ff || ready2;
   assign ready0   = !s0_valid_ff || ready1;
   assign req.ready = ready0;

   assign s0_valid_in  = ready0   ? req.valid   : s0_valid_ff;
   assign s1_valid_in  = ready1   ? s0_valid_ff : s1_valid_ff;
   assign s2_valid_in  = ready2   ? s1_valid_ff : s2_valid_ff;
   assign rsp_valid_in = out_load ? s2_valid_ff : rsp_valid_ff;

   // input register
   always_comb begin
      s0_in = s0_ff;
      if (ready0 && req.valid) begin
         s0_in.kind  = req.req_type;
         s0_in.state = bslb_pkg::build_state_type'(req.new_state);
         s0_in.ms    = req.elapsed_ms;
      end
   end

   // quotient estimate, never above the true quotient and at most one below
   always_comb begin
      prod_est = MS_W'(s0_ff.ms) * RECIP;
      s1_in    = s1_ff;
      if (ready1 && s0_valid_ff) begin
         s1_in.kind  = s0_ff.kind;
         s1_in.state = s0_ff.state;
         s1_in.ms    = s0_ff.ms;
         s1_in.q_est = prod_est[bslb_pkg::RECIP_SHIFT +: MS_W];
      end
   end

   // remainder and one correction step
   always_comb begin
      prod_back = s1_ff.q_est * PERIOD;
      r_est     = s1_ff.ms - prod_back[MS_W-1:0];
      s2_in     = s2_ff;
      if (ready2 && s1_valid_ff) begin
         s2_in.kind  = s1_ff.kind;
         s2_in.state = s1_ff.state;
         s2_in.ms    = s1_ff.ms;
         if (r_est >= MS_W'(PERIOD)) begin
            s2_in.qm = s1_ff.q_est + MS_W'(1);
            s2_in.rm = PERIOD_W'(r_est - MS_W'(PERIOD));
         end else begin
            s2_in.qm = s1_ff.q_est;
            s2_in.rm = PERIOD_W'(r_est);
         end
      end
   end

   // time left minus elapsed, both as periods plus remainder
   always_comb begin
      q_wide    = MS_W'(q_ff);
      tick_ends = (q_wide < s2_ff.qm) || ((q_wide == s2_ff.qm) && (r_ff < s2_ff.rm));
      borrow    = r_ff < s2_ff.rm;
      r_sum     = {1'b0, r_ff} + (borrow ? {1'b0, PERIOD} : '0) - {1'b0, s2_ff.rm};
      r_next    = r_sum[PERIOD_W-1:0];
      q_next    = q_ff - s2_ff.qm[TIME_W-1:0] - TIME_W'(borrow);
      own       = bslb_pkg::own_lamp(state_ff);
   end

   // state update as a request enters the response register
   always_comb begin
      state_in  = state_ff;
      q_in      = q_ff;
      r_in      = r_ff;
      active_in = active_ff;
      lamp_in   = lamp_ff;
      if (s2_valid_ff && out_load) begin
         if (s2_ff.kind == bslb_pkg::REQ_SET) begin
            state_in = s2_ff.state;
            lamp_in  = (lamp_ff & bslb_pkg::keep_mask(s2_ff.state))
                     | bslb_pkg::own_lamp(s2_ff.state);
            if (s2_ff.state != state_ff) begin
               q_in      = START_Q;
               r_in      = START_R;
               active_in = 1'b1;
            end
         end else if (active_ff) begin
            if (tick_ends) begin
               q_in      = '0;
               r_in      = '0;
               active_in = 1'b0;
               lamp_in   = lamp_ff | own;
            end else begin
               q_in    = q_next;
               r_in    = r_next;
               lamp_in = q_next[0] ? (lamp_ff & ~own) : (lamp_ff | own);
            end
         end
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= bslb_pkg::BUILD_DISCONNECTED;
         q_ff         <= START_Q;
         r_ff         <= START_R;
         active_ff    <= 1'b1;
         lamp_ff      <= bslb_pkg::own_lamp(bslb_pkg::BUILD_DISCONNECTED);
      end else begin
         s0_valid_ff  <= s0_valid_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
         q_ff         <= q_in;
         r_ff         <= r_in;
         active_ff    <= active_in;
         lamp_ff      <= lamp_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s0_ff <= s0_in;
      s1_ff <= s1_in;
      s2_ff <= s2_in;
   end

   // response
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.red_lamp    = lamp_ff[bslb_pkg::LAMP_RED];
   assign rsp.green_lamp  = lamp_ff[bslb_pkg::LAMP_GREEN];
   assign rsp.yellow_lamp = lamp_ff[bslb_pkg::LAMP_YELLOW];
   assign rsp.animating   = active_ff;

   // checks
   assign split_ok = ((32'(s2_ff.qm) * 32'(PERIOD) + 32'(s2_ff.rm)) == 32'(s2_ff.ms))
                   && (s2_ff.rm < PERIOD);

   `include "build_status_lamp_blinker_assert.svh"

   `BSLB_ASSERT(remainder_below_period, r_ff < PERIOD, "stored remainder out of range")
   `BSLB_ASSERT_IMPL(idle_time_zero, !active_ff, (q_ff == '0) && (r_ff == '0), "idle with time left")
   `BSLB_ASSERT_IMPL(idle_lamp_lit, !active_ff, (lamp_ff & own) != '0, "idle with own lamp dark")
   `BSLB_ASSERT_IMPL(divide_exact, s2_valid_ff, split_ok, "elapsed split wrong")

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
module tb_top;
   import bslb_pkg::*;

   localparam int unsigned BLINK_PERIOD_MS = BLINK_PERIOD_MS_DEF;
   localparam int unsigned BLINK_COUNT     = BLINK_COUNT_DEF;
   localparam int BLINK_FULL  = 2 * BLINK_PERIOD_MS * BLINK_COUNT;
   localparam int BLINK_LOAD  = (BLINK_FULL > TIME_MAX) ? TIME_MAX : BLINK_FULL;
   localparam int N_RANDOM    = 930;
   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 400;
   localparam int HOLD_AT     = 250;
   localparam int N_PLAN      = 24;

   // lamps and animation flag as one response carries them
   typedef struct packed {
      logic red;
      logic green;
      logic yellow;
      logic anim;
   } lamp_view_type;

   typedef struct packed {
      logic            kind;
      build_state_type st;
      logic [MS_W-1:0] ms;
      logic            typed;
      lamp_view_type   want;
   } step_row_type;

   logic clock;
   logic reset;

   bslb_req_if req_ch();
   bslb_rsp_if rsp_ch();

   build_status_lamp_blinker #(
      .BLINK_PERIOD_MS(BLINK_PERIOD_MS),
      .BLINK_COUNT    (BLINK_COUNT)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch)
   );

   // shadow of the blinker state
   build_state_type cur_state;
   int              time_left;
   bit              blinking;
   lamp_type        lamps;

   lamp_view_type lamps_due[$];
   int            n_bad;
   int            n_seen;
   int            stall_cycles;
   bit            fast_sender;
   bit            fast_taker;

   // directed requests, typed expectations where they are obvious
   step_row_type plan [N_PLAN] = '{
      '{REQ_TICK, BUILD_RUNNING,      16'd0,     1'b1, 4'b0011},
      '{REQ_TICK, BUILD_RUNNING,      16'd500,   1'b1, 4'b0001},
      '{REQ_SET,  BUILD_CORRECT,      16'hFFFF,  1'b1, 4'b0101},
      '{REQ_SET,  BUILD_RUNNING,      16'd0,     1'b1, 4'b0111},
      '{REQ_SET,  BUILD_RUNNING,      16'd0,     1'b1, 4'b0111},
      '{REQ_TICK, BUILD_INCORRECT,    16'd2999,  1'b1, 4'b0111},
      '{REQ_TICK, BUILD_RUNNING,      16'd1,     1'b1, 4'b0111},
      '{REQ_TICK, BUILD_RUNNING,      16'd1,     1'b1, 4'b0110},
      '{REQ_TICK, BUILD_RUNNING,      16'hFFFF,  1'b1, 4'b0110},
      '{REQ_SET,  BUILD_INCORRECT,    16'd0,     1'b1, 4'b1001},
      '{REQ_TICK, BUILD_RUNNING,      16'hFFFF,  1'b1, 4'b1000},
      '{REQ_SET,  BUILD_INCORRECT,    16'd0,     1'b1, 4'b1000},
      '{REQ_SET,  BUILD_DISCONNECTED, 16'd0,     1'b1, 4'b0011},
      '{REQ_TICK, BUILD_RUNNING,      16'd1000,  1'b1, 4'b0011},
      '{REQ_TICK, BUILD_RUNNING,      16'd499,   1'b1, 4'b0001},
      '{REQ_SET,  BUILD_CORRECT,      16'd0,     1'b1, 4'b0101},
      '{REQ_TICK, BUILD_RUNNING,      16'd750,   1'b0, 4'b0000},
      '{REQ_TICK, BUILD_RUNNING,      16'hAAAA,  1'b0, 4'b0000},
      '{REQ_SET,  BUILD_RUNNING,      16'h5555,  1'b1, 4'b0111},
      '{REQ_TICK, BUILD_RUNNING,      16'd3000,  1'b1, 4'b0111},
      '{REQ_TICK, BUILD_RUNNING,      16'd0,     1'b1, 4'b0111},
      '{REQ_TICK, BUILD_RUNNING,      16'hFFFF,  1'b1, 4'b0110},
      '{REQ_SET,  BUILD_DISCONNECTED, 16'd0,     1'b0, 4'b0000},
      '{REQ_TICK, BUILD_RUNNING,      16'd2600,  1'b0, 4'b0000}
   };

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // next lamps of the shadow state for one accepted request
   function automatic lamp_view_type predict_lamps(input logic kind, input build_state_type st,
                                                   input logic [MS_W-1:0] ms);
      lamp_view_type view;
      bit            drive;
      bit            lit;
      int            own;
      drive = 1'b1;
      lit   = 1'b1;
      if (kind == REQ_SET) begin
         // each state clears its own set of lamps, running clears none
         case (st)
            BUILD_DISCONNECTED: begin
               lamps[LAMP_RED]   = 1'b0;
               lamps[LAMP_GREEN] = 1'b0;
            end
            BUILD_CORRECT: begin
               lamps[LAMP_RED]    = 1'b0;
               lamps[LAMP_YELLOW] = 1'b0;
            end
            BUILD_INCORRECT: begin
               lamps[LAMP_GREEN]  = 1'b0;
               lamps[LAMP_YELLOW] = 1'b0;
            end
            default: begin
            end
         endcase
         if (st != cur_state) begin
            time_left = BLINK_LOAD;
            blinking  = 1'b1;
         end
         cur_state = st;
      end else if (!blinking) begin
         drive = 1'b0;
      end else if (time_left < int'(ms)) begin
         // overshoot ends the animation with the lamp lit
         time_left = 0;
         blinking  = 1'b0;
      end else begin
         time_left = time_left - int'(ms);
         lit = ((time_left / BLINK_PERIOD_MS) % 2) == 0;
      end
      if (drive) begin
         case (cur_state)
            BUILD_CORRECT:   own = LAMP_GREEN;
            BUILD_INCORRECT: own = LAMP_RED;
            default:         own = LAMP_YELLOW;
         endcase
         lamps[own] = lit;
      end
      view.red    = lamps[LAMP_RED];
      view.green  = lamps[LAMP_GREEN];
      view.yellow = lamps[LAMP_YELLOW];
      view.anim   = blinking;
      return view;
   endfunction

   // offer one request after a random gap and wait until it is taken
   task automatic offer_request(input logic kind, input build_state_type st,
                                input logic [MS_W-1:0] ms, input logic typed,
                                input lamp_view_type want);
      int unsigned   gap;
      lamp_view_type guess;
      gap = fast_sender ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.req_type   <= kind;
      req_ch.new_state  <= st;
      req_ch.elapsed_ms <= ms;
      do @(posedge clock); while (!req_ch.ready);
      guess = predict_lamps(kind, st, ms);
      lamps_due.push_back(typed ? want : guess);
   endtask

   // elapsed times biased towards the blink period boundaries
   function automatic logic [MS_W-1:0] pick_ms();
      int unsigned r;
      int          v;
      r = $urandom_range(0, 9);
      case (r)
         6: begin
            v = BLINK_PERIOD_MS * $urandom_range(0, 6) + $urandom_range(0, 2) - 1;
            if (v < 0)
               v = 0;
         end
         7:       v = $urandom_range(0, BLINK_LOAD + 200);
         8:       v = 0;
         9:       v = $urandom_range(0, 65535);
         default: v = $urandom_range(0, 700);
      endcase
      return MS_W'(v);
   endfunction

   // stimulus
   initial begin
      int              n_sent;
      int              n_ticks;
      build_state_type st;
      lamp_view_type   none;
      none              = '0;
      n_sent            = 0;
      fast_sender       = 1'b0;
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.req_type   <= REQ_SET;
      req_ch.new_state  <= BUILD_RUNNING;
      req_ch.elapsed_ms <= '0;
      // state of a freshly attached controller
      cur_state = BUILD_DISCONNECTED;
      time_left = BLINK_LOAD;
      blinking  = 1'b1;
      lamps     = '0;
      lamps[LAMP_YELLOW] = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed part
      foreach (plan[i])
         offer_request(plan[i].kind, plan[i].st, plan[i].ms, plan[i].typed, plan[i].want);

      // random part: mostly a state change followed by ticks, some noise
      while (n_sent < N_RANDOM) begin
         fast_sender = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 9) < 8) begin
            st = ($urandom_range(0, 3) == 0) ? cur_state
                                             : build_state_type'($urandom_range(0, 3));
            offer_request(REQ_SET, st, MS_W'($urandom_range(0, 65535)), 1'b0, none);
            n_ticks = $urandom_range(0, 8);
            n_sent  = n_sent + 1 + n_ticks;
            repeat (n_ticks)
               offer_request(REQ_TICK, build_state_type'($urandom_range(0, 3)), pick_ms(),
                             1'b0, none);
         end else begin
            n_ticks = $urandom_range(1, 4);
            n_sent  = n_sent + n_ticks;
            repeat (n_ticks)
               offer_request(logic'($urandom_range(0, 1)),
                             build_state_type'($urandom_range(0, 3)),
                             MS_W'($urandom_range(0, 65535)), 1'b0, none);
         end
      end
      req_ch.valid <= 1'b0;

      // drain, then wait for any stray response
      while (lamps_due.size() != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);
      if (n_bad == 0 && lamps_due.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // response side: random stalls, bursts and one long hold-off
   initial begin
      int unsigned   w;
      lamp_view_type got;
      lamp_view_type want;
      n_bad         = 0;
      n_seen        = 0;
      fast_taker    = 1'b0;
      rsp_ch.ready <= 1'b0;
      @(negedge reset);
      @(posedge clock);
      forever begin
         if (n_seen == HOLD_AT)
            w = HOLD_CYCLES;
         else if (fast_taker)
            w = 0;
         else
            w = $urandom_range(0, 9);
         if (w > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (w) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         got.red    = rsp_ch.red_lamp;
         got.green  = rsp_ch.green_lamp;
         got.yellow = rsp_ch.yellow_lamp;
         got.anim   = rsp_ch.animating;
         n_seen = n_seen + 1;
         if (n_seen % 40 == 0)
            fast_taker = ($urandom_range(0, 3) == 0);
         if (lamps_due.size() == 0) begin
            n_bad = n_bad + 1;
            if (n_bad <= 10)
               $display("response %0d with no request pending: r%b g%b y%b a%b",
                        n_seen, got.red, got.green, got.yellow, got.anim);
         end else begin
            want = lamps_due.pop_front();
            if (got.red !== want.red || got.green !== want.green ||
                got.yellow !== want.yellow || got.anim !== want.anim) begin
               n_bad = n_bad + 1;
               if (n_bad <= 10)
                  $display("response %0d mismatch: expected r%b g%b y%b a%b, got r%b g%b y%b a%b",
                           n_seen, want.red, want.green, want.yellow, want.anim,
                           got.red, got.green, got.yellow, got.anim);
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule

// ----- build_status_lamp_blinker.f -----
+incdir+hdl
hdl/bslb_pkg.sv
hdl/bslb_if.sv
hdl/build_status_lamp_blinker.sv
test/tb_top.sv
